/* sv/jrha_pkg.sv */
package jrha_pkg;

  localparam int MAX_JOINTS_DEF = 256;

  localparam logic CFG_DIRECTION_MODE = 1'b0;
  localparam logic CFG_JOINTS_IN_USE  = 1'b1;

  localparam logic MODE_REL_TO_ABS = 1'b0;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  typedef struct packed {
    logic [7:0] joint;
    quat_t      q;
    logic       convert;
    logic       err;
    logic       wr;
  } meta_t;

  function automatic logic signed [15:0] round_sat(input logic signed [34:0] s);
    logic signed [34:0] v;
    logic signed [20:0] t;
    begin
      v = s + 35'sd8192;
      t = v[34:14];
      if (t > 21'sd32767) begin
        round_sat = 16'sh7fff;
      end else if (t < -21'sd32768) begin
        round_sat = 16'sh8000;
      end else begin
        round_sat = t[15:0];
      end
    end
  endfunction

endpackage

/* sv/jrha_store.sv */
module jrha_store #(
  parameter int MAX_JOINTS = jrha_pkg::MAX_JOINTS_DEF,
  parameter int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
  input  logic            clk_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output jrha_pkg::quat_t rdata_o,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  jrha_pkg::quat_t wdata_i
);

  jrha_pkg::quat_t mem [MAX_JOINTS];
  jrha_pkg::quat_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/jrha_qmul.sv */
module jrha_qmul (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic            conj_i,
  input  jrha_pkg::quat_t p_i,
  input  jrha_pkg::quat_t q_i,
  output jrha_pkg::quat_t r_o
);

  logic signed [16:0] pv [4];
  logic signed [15:0] qv [4];
  logic signed [32:0] prod_q [4][4];
  logic signed [34:0] sw, sx, sy, sz;

  always_comb begin
    pv[0] = 17'(p_i.w);
    pv[1] = conj_i ? -17'(p_i.x) : 17'(p_i.x);
    pv[2] = conj_i ? -17'(p_i.y) : 17'(p_i.y);
    pv[3] = conj_i ? -17'(p_i.z) : 17'(p_i.z);
    qv[0] = q_i.w;
    qv[1] = q_i.x;
    qv[2] = q_i.y;
    qv[3] = q_i.z;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_q[i][j] <= pv[i] * 33'(qv[j]);
        end
      end
    end
  end

  always_comb begin
    sw = 35'(prod_q[0][0]) - 35'(prod_q[1][1]) - 35'(prod_q[2][2]) - 35'(prod_q[3][3]);
    sx = 35'(prod_q[0][1]) + 35'(prod_q[1][0]) + 35'(prod_q[2][3]) - 35'(prod_q[3][2]);
    sy = 35'(prod_q[0][2]) - 35'(prod_q[1][3]) + 35'(prod_q[2][0]) + 35'(prod_q[3][1]);
    sz = 35'(prod_q[0][3]) + 35'(prod_q[1][2]) - 35'(prod_q[2][1]) + 35'(prod_q[3][0]);
    r_o.w = jrha_pkg::round_sat(sw);
    r_o.x = jrha_pkg::round_sat(sx);
    r_o.y = jrha_pkg::round_sat(sy);
    r_o.z = jrha_pkg::round_sat(sz);
  end

endmodule

/* sv/joint_rotation_hierarchy_accumulate.sv */
// Joint rotation hierarchy accumulator.
// Input stream s_axis: one joint per item, in ascending index order, with its
// parent index and a Q2.14 quaternion. Output stream m_axis: one item per input
// item, in order, with the converted quaternion and the order error flag.
// Configuration channel cfg_*: direction mode (index 0) and joints in use
// (index 1); always ready. The user must write it only while the block is
// idle; the block itself does not enforce this. Each accepted item goes through
// the store read, the products and sum/round/saturate into the output register.
// Throughput: one item per cycle for independent joints while the output does
// not stall. A joint whose parent is still in the pipeline waits until the
// parent's absolute rotation is written back to the store, so a child directly
// after its parent waits on the read-modify-write loop through the store.
// Reset clears the configuration and the pipeline; the store contents are
// undefined until each joint is written. When the receiver stalls, the output
// register holds its item and the pipeline fills up to three items before
// s_axis_tready drops.
module joint_rotation_hierarchy_accumulate #(
  parameter int MAX_JOINTS = jrha_pkg::MAX_JOINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // joint_index, parent_index, rot_w, rot_x, rot_y, rot_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // out_joint, out_w, out_x, out_y, out_z
  output logic [0:0]  m_axis_tuser,  // order_error
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  localparam int AW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int IDXW = (AW > 9) ? AW : 9;

  logic       mode_q;
  logic [8:0] jiu_q;

  logic [7:0]        in_joint;
  logic signed [8:0] in_parent;
  jrha_pkg::quat_t   in_q;
  logic [IDXW-1:0]   paddr_ext, waddr_ext;
  logic [AW-1:0]     raddr, waddr;

  jrha_pkg::meta_t in_meta, a_q, b_q;
  logic            a_valid_q, b_valid_q, o_valid_q;
  logic [7:0]      o_joint_q;
  jrha_pkg::quat_t o_r_q;
  logic            o_err_q;

  logic            accept, hazard, out_free, b_adv, b_free, a_adv, a_free;
  jrha_pkg::quat_t rdata, prod_r, result, wdata;
  logic            we;

  assign in_joint  = s_axis_tdata[7:0];
  assign in_parent = s_axis_tdata[16:8];
  assign in_q.w    = s_axis_tdata[32:17];
  assign in_q.x    = s_axis_tdata[48:33];
  assign in_q.y    = s_axis_tdata[64:49];
  assign in_q.z    = s_axis_tdata[80:65];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jrha_pkg::MODE_REL_TO_ABS;
      jiu_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        jrha_pkg::CFG_DIRECTION_MODE: mode_q <= cfg_data_i[0];
        jrha_pkg::CFG_JOINTS_IN_USE:  jiu_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_meta.joint   = in_joint;
    in_meta.q       = in_q;
    in_meta.err     = !in_parent[8] && (in_parent >= $signed({1'b0, in_joint}));
    in_meta.wr      = {24'd0, in_joint} < 32'(MAX_JOINTS);
    in_meta.convert = !in_parent[8] && !in_meta.err && in_meta.wr &&
                      ({1'b0, in_joint} < jiu_q);
  end

  assign out_free = !o_valid_q || m_axis_tready;
  assign b_adv    = b_valid_q && out_free;
  assign b_free   = !b_valid_q || b_adv;
  assign a_adv    = a_valid_q && b_free;
  assign a_free   = !a_valid_q || a_adv;

  // hold a child while its parent has not yet been written back
  assign hazard = !in_parent[8] &&
                  ((a_valid_q && a_q.wr && (a_q.joint == in_parent[7:0])) ||
                   (b_valid_q && b_q.wr && (b_q.joint == in_parent[7:0])));

  assign s_axis_tready = a_free && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign paddr_ext = IDXW'(unsigned'(in_parent));
  assign raddr     = paddr_ext[AW-1:0];
  assign waddr_ext = IDXW'(b_q.joint);
  assign waddr     = waddr_ext[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_q <= accept;
      end
      if (b_free) begin
        b_valid_q <= a_adv;
      end
      if (out_free) begin
        o_valid_q <= b_adv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= in_meta;
    end
    if (a_adv) begin
      b_q <= a_q;
    end
    if (b_adv) begin
      o_joint_q <= b_q.joint;
      o_r_q     <= result;
      o_err_q   <= b_q.err;
    end
  end

  jrha_store #(
    .MAX_JOINTS (MAX_JOINTS),
    .AW         (AW)
  ) u_store (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  jrha_qmul u_qmul (
    .clk_i  (clk_i),
    .en_i   (a_adv),
    .conj_i (mode_q),
    .p_i    (rdata),
    .q_i    (a_q.q),
    .r_o    (prod_r)
  );

  assign result = b_q.convert ? prod_r : b_q.q;
  assign wdata  = (mode_q == jrha_pkg::MODE_REL_TO_ABS) ? result : b_q.q;
  assign we     = b_adv && b_q.wr;

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {o_r_q.z, o_r_q.y, o_r_q.x, o_r_q.w, o_joint_q};
  assign m_axis_tuser  = o_err_q;

  a_no_read_during_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_parent[8] |-> !(we && (b_q.joint == in_parent[7:0])))
    else $error("store read of a joint being written back");

  a_b_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv |=> m_axis_tvalid)
    else $error("finished item missing at output");

  a_accept_fills_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> a_valid_q)
    else $error("accepted item lost before products");

endmodule
